### rtl/mest_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mest_pkg
// Shared types and constants for the multicore earliest start time core.
// ----------------------------------------------------------------------------
package mest_pkg;

  localparam int NUM_CORES  = 16;
  localparam int MAX_LEVELS = 64;
  localparam int CORE_W     = 4;
  localparam int LEVEL_W    = 7;
  localparam int LVL_IDX_W  = $clog2(MAX_LEVELS);
  localparam int CORE_IDX_W = $clog2(NUM_CORES);
  localparam int TIME_W     = 32;
  localparam int COST_W     = 16;
  localparam int MAXE_DEPTH = MAX_LEVELS * NUM_CORES;
  localparam int MAXE_AW    = $clog2(MAXE_DEPTH);
  localparam int CNT_W      = $clog2(NUM_CORES + 1);

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_ROUTE = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [CORE_W-1:0]  core;
    logic [LEVEL_W-1:0] prec_level;
    logic [TIME_W-1:0]  end_time;
    logic [CORE_W-1:0]  peer_core;
    logic [COST_W-1:0]  route_cost;
  } in_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] core_idle_time;
    logic [TIME_W-1:0] makespan;
  } out_word_t;

  // token handed cell to cell during a query scan
  typedef struct packed {
    logic              vld;
    logic [TIME_W-1:0] val;
  } scan_tok_t;

  // control broadcast to the cells
  typedef struct packed {
    logic                  clr;
    logic                  route_we;
    logic [CORE_IDX_W-1:0] route_a;
    logic [CORE_IDX_W-1:0] route_b;
    logic [COST_W-1:0]     route_cost;
    logic [CORE_IDX_W-1:0] qcore;
    logic                  use_route;
  } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/mest_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mest_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mest_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/mest_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mest_cell
// One core's slice: route cost row for this core, and one step of the scan
// chain. Adds the route cost, when routing is enabled, to the level maximum
// entering here and folds it into the running maximum that passes through.
// ----------------------------------------------------------------------------
module mest_cell
  import mest_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [CORE_IDX_W-1:0] my_idx,
  input  wire cell_ctl_t             ctl,
  input  wire logic                  inj_vld,
  input  wire logic [TIME_W-1:0]     inj_val,
  input  wire scan_tok_t             tok_in,
  output scan_tok_t                  tok_out
);

  // route cost between this core and every other core
  logic [COST_W-1:0] cost_r [NUM_CORES];
  scan_tok_t         tok_r;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] sat;
  logic [TIME_W-1:0] fold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CORES; i++) cost_r[i] <= '0;
    end else if (ctl.route_we) begin
      if (ctl.route_a == my_idx) cost_r[ctl.route_b] <= ctl.route_cost;
      else if (ctl.route_b == my_idx) cost_r[ctl.route_a] <= ctl.route_cost;
    end
  end

  always_comb begin
    sum = {1'b0, inj_val} +
          ((ctl.use_route) ? {{(TIME_W+1-COST_W){1'b0}}, cost_r[ctl.qcore]} : '0);
    sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    fold = tok_in.val;
    if (inj_vld && (!tok_in.vld || sat > tok_in.val)) fold = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_in.vld || inj_vld;
    end
    tok_r.val <= fold;
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

### rtl/multicore_earliest_start_time_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multicore_earliest_start_time_core
// Tracks per-core and per-level end times and answers earliest start queries.
// ----------------------------------------------------------------------------
// One word at a time. After reset a clearing pass zeroes all MAXE_DEPTH (1024)
// entries of the level maximum RAM and their valid marks; in_ready stays low
// until it ends. An add passes through accept, RAM read, RAM write and result;
// a route write or other word goes from accept straight to result; in a query
// the level maxima stream out of the RAM one core per cycle and each enters
// the routing cell of its core, which adds the route cost when routing is
// enabled and folds it into a running maximum that walks down the chain in
// step with the reads. A word waits in its last cycle while the output
// register still holds an unaccepted result.
module multicore_earliest_start_time_core
  import mest_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  state_t state_r, state_nxt;
  logic use_route_r;
  in_word_t item_r;
  logic [TIME_W-1:0] last_end_r [NUM_CORES];
  logic [MAXE_AW-1:0] clr_addr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0] best_r, best_nxt;
  logic out_valid_r;
  out_word_t out_r;
  out_word_t out_next;

  logic accept;
  logic lvl_ok, q_ok;
  logic [LVL_IDX_W-1:0] lidx, qlidx;
  logic [MAXE_AW-1:0] add_addr, ram_raddr, ram_waddr;
  logic ram_we;
  logic [TIME_W:0] ram_rdata, ram_wdata;
  logic [TIME_W-1:0] idle;
  cell_ctl_t ctl;
  scan_tok_t tok [NUM_CORES+1];
  logic issue;
  logic [CORE_IDX_W-1:0] issue_core;
  logic issue_vld_r;
  logic [CORE_IDX_W-1:0] issue_core_r;
  logic [CORE_IDX_W-1:0] icore;

  assign icore  = item_r.core[CORE_IDX_W-1:0];
  assign accept = in_valid && in_ready;
  assign lvl_ok = (item_r.prec_level >= LEVEL_W'(1)) &&
                  (item_r.prec_level <= LEVEL_W'(MAX_LEVELS));
  assign lidx   = LVL_IDX_W'(item_r.prec_level - LEVEL_W'(1));
  assign q_ok   = (item_r.prec_level >= LEVEL_W'(2)) &&
                  (item_r.prec_level <= LEVEL_W'(MAX_LEVELS + 1));
  assign qlidx  = LVL_IDX_W'(item_r.prec_level - LEVEL_W'(2));
  assign add_addr = {lidx, icore};
  assign idle   = last_end_r[icore];

  assign issue      = (state_r == ST_SCAN) && q_ok;
  assign issue_core = cnt_r[CORE_IDX_W-1:0];
  assign ram_raddr  = (state_r == ST_SCAN) ? {qlidx, issue_core} : add_addr;
  // RAM entry: valid mark on top of the level maximum
  assign ram_we     = (state_r == ST_CLEAR) || ((state_r == ST_ADD_WR) && lvl_ok);
  assign ram_waddr  = (state_r == ST_CLEAR) ? clr_addr_r : add_addr;
  assign ram_wdata  = (state_r == ST_CLEAR) ? '0 :
                      {1'b1, (ram_rdata[TIME_W] &&
                              ram_rdata[TIME_W-1:0] > item_r.end_time) ?
                             ram_rdata[TIME_W-1:0] : item_r.end_time};

  mest_ram #(.WIDTH(TIME_W + 1), .DEPTH(MAXE_DEPTH)) u_maxe (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_vld_r <= 1'b0;
    end else begin
      issue_vld_r <= issue;
    end
    issue_core_r <= issue_core;
  end

  always_comb begin
    ctl.clr        = (state_r == ST_IDLE);
    ctl.route_we   = (state_r == ST_DONE) && (item_r.func == FUNC_ROUTE);
    ctl.route_a    = icore;
    ctl.route_b    = item_r.peer_core[CORE_IDX_W-1:0];
    ctl.route_cost = item_r.route_cost;
    ctl.qcore      = icore;
    ctl.use_route  = use_route_r;
  end

  assign tok[0] = '{vld: 1'b0, val: '0};

  // RAM data for core g enters cell g in the same cycle the running maximum
  // from the cells before it arrives there
  for (genvar g = 0; g < NUM_CORES; g++) begin : g_cell
    logic inj;
    assign inj = issue_vld_r && ram_rdata[TIME_W] && (issue_core_r == CORE_IDX_W'(g));
    mest_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .my_idx  (CORE_IDX_W'(g)),
      .ctl     (ctl),
      .inj_vld (inj),
      .inj_val (ram_rdata[TIME_W-1:0]),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    best_nxt  = best_r;
    if (tok[NUM_CORES].vld && tok[NUM_CORES].val > best_r) begin
      best_nxt = tok[NUM_CORES].val;
    end
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == MAXE_AW'(MAXE_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          case (in_data.func)
            FUNC_ADD:   state_nxt = ST_ADD_RD;
            FUNC_QUERY: state_nxt = ST_SCAN;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ADD_RD: state_nxt = ST_ADD_WR;
      ST_ADD_WR: state_nxt = ST_DONE;
      ST_SCAN: begin
        if (cnt_r == CNT_W'(0)) best_nxt = idle;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_CORES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last core enters the chain, then its token reaches the end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      use_route_r <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      for (int i = 0; i < NUM_CORES; i++) last_end_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) use_route_r <= cfg_wdata;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + MAXE_AW'(1);
      if (state_r == ST_ADD_WR) begin
        last_end_r[icore] <= item_r.end_time;
      end
      if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // makespan: max tree over the core last ends
  always_comb begin
    logic [TIME_W-1:0] mx [NUM_CORES];
    for (int i = 0; i < NUM_CORES; i++) mx[i] = last_end_r[i];
    for (int s = 1; s < NUM_CORES; s = s * 2) begin
      for (int i = 0; i + s < NUM_CORES; i = i + 2 * s) begin
        if (mx[i + s] > mx[i]) mx[i] = mx[i + s];
      end
    end
    out_next.start_time     = (item_r.func == FUNC_QUERY) ? best_r : '0;
    out_next.core_idle_time = idle;
    out_next.makespan       = mx[0];
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    best_r <= best_nxt;
    if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_r <= out_next;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data)) else $error("output changed");
  a_nop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && item_r.func != FUNC_QUERY |-> out_data.start_time == '0)
    else $error("nonzero start");
`endif

endmodule

`default_nettype wire

### dv/tb_multicore_earliest_start_time_core.sv
// ----------------------------------------------------------------------------
// tb_multicore_earliest_start_time_core
// Drives add, query, route-cost and no-op words into the scheduler core with bursty
// input and a stalling receiver; a scoreboard predicts each result word from
// its own copy of the schedule state and checks the outputs in order.
// ----------------------------------------------------------------------------
class sched_scoreboard;
  logic [31:0] last_end [16];
  logic [31:0] lvl_max [1024];
  bit          lvl_vld [1024];
  logic [15:0] cost_tbl [256];
  bit          routing;
  mest_pkg::out_word_t pending[$];
  int          errors;

  function void clear();
    for (int i = 0; i < 16; i++) last_end[i] = '0;
    for (int i = 0; i < 1024; i++) begin
      lvl_max[i] = '0;
      lvl_vld[i] = 0;
    end
    for (int i = 0; i < 256; i++) cost_tbl[i] = '0;
    routing = 1;
    errors = 0;
  endfunction

  function logic [31:0] span();
    logic [31:0] m;
    m = '0;
    for (int i = 0; i < 16; i++) if (last_end[i] > m) m = last_end[i];
    return m;
  endfunction

  function logic [31:0] earliest(logic [3:0] c, logic [6:0] lvl);
    logic [32:0] t;
    logic [32:0] v;
    int          idx;
    t = {1'b0, last_end[c]};
    if (lvl <= 1 || lvl - 1 > 64) return t[31:0];
    for (int p = 0; p < 16; p++) begin
      idx = (lvl - 2) * 16 + p;
      if (lvl_vld[idx]) begin
        v = {1'b0, lvl_max[idx]};
        if (routing) v = v + cost_tbl[c * 16 + p];
        if (v > 33'hFFFF_FFFF) v = 33'hFFFF_FFFF;
        if (v > t) t = v;
      end
    end
    return t[31:0];
  endfunction

  function void note_input(mest_pkg::in_word_t w);
    mest_pkg::out_word_t r;
    int idx;
    r = '0;
    case (w.func)
      mest_pkg::FUNC_ADD: begin
        last_end[w.core] = w.end_time;
        if (w.prec_level >= 1 && w.prec_level <= 64) begin
          idx = (w.prec_level - 1) * 16 + w.core;
          if (!lvl_vld[idx] || w.end_time > lvl_max[idx]) lvl_max[idx] = w.end_time;
          lvl_vld[idx] = 1;
        end
      end
      mest_pkg::FUNC_QUERY: r.start_time = earliest(w.core, w.prec_level);
      mest_pkg::FUNC_ROUTE: begin
        cost_tbl[w.core * 16 + w.peer_core] = w.route_cost;
        cost_tbl[w.peer_core * 16 + w.core] = w.route_cost;
      end
      default: ;
    endcase
    r.core_idle_time = last_end[w.core];
    r.makespan = span();
    pending.insert(pending.size(), r);
  endfunction

  function void check_result(mest_pkg::out_word_t got);
    mest_pkg::out_word_t exp_w;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, got);
      errors++;
      return;
    end
    exp_w = pending.pop_front();
    if (got.start_time !== exp_w.start_time) begin
      $display("%0t: start_time exp %h got %h", $time, exp_w.start_time, got.start_time);
      errors++;
    end
    if (got.core_idle_time !== exp_w.core_idle_time) begin
      $display("%0t: core_idle_time exp %h got %h", $time, exp_w.core_idle_time,
               got.core_idle_time);
      errors++;
    end
    if (got.makespan !== exp_w.makespan) begin
      $display("%0t: makespan exp %h got %h", $time, exp_w.makespan, got.makespan);
      errors++;
    end
  endfunction
endclass

module tb_multicore_earliest_start_time_core;
  import mest_pkg::*;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      cfg_we = 0;
  logic      cfg_wdata = 0;
  logic      in_valid = 0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_word_t out_data;

  sched_scoreboard sb;
  bit        hold_off = 0;
  bit        stall_en = 1;
  int        idle_cycles = 0;

  multicore_earliest_start_time_core uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // score at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("tb_multicore_earliest_start_time_core: FAIL");
        $finish;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else if (!stall_en) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // valid and data change only at falling edges
  task automatic send_word(in_word_t w);
    in_valid = 1;
    in_data = w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic gap();
    repeat ($urandom_range(0, 4)) @(negedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic set_routing(bit v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.routing = v;
  endtask

  function automatic in_word_t mk(logic [1:0] f, logic [3:0] c, logic [6:0] l,
                                  logic [31:0] e, logic [3:0] p, logic [15:0] rc);
    in_word_t w;
    w.func = f; w.core = c; w.prec_level = l; w.end_time = e;
    w.peer_core = p; w.route_cost = rc;
    return w;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int k;
    w = '0;
    w.core = 4'($urandom_range(0, 15));
    w.peer_core = 4'($urandom_range(0, 15));
    w.route_cost = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
    k = $urandom_range(0, 9);
    // mostly small levels so queries find recorded predecessors
    w.prec_level = (k == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 6));
    k = $urandom_range(0, 9);
    w.end_time = (k == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15) : $urandom;
    k = $urandom_range(0, 19);
    if (k < 9) w.func = FUNC_ADD;
    else if (k < 17) w.func = FUNC_QUERY;
    else if (k < 19) w.func = FUNC_ROUTE;
    else w.func = FUNC_NOP;
    return w;
  endfunction

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        send_word(rand_word());
        burst--; n--;
      end
      gap();
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extremes, all funcs, level 0/1/65+, saturation
    send_word(mk(FUNC_QUERY, 0, 1, 0, 0, 0));
    send_word(mk(FUNC_QUERY, 15, 7'd127, 0, 0, 0));
    send_word(mk(FUNC_ADD, 0, 1, 32'hFFFF_FFFF, 0, 0));
    send_word(mk(FUNC_ROUTE, 3, 0, 0, 15, 16'hFFFF));
    send_word(mk(FUNC_ROUTE, 15, 0, 0, 0, 16'hFFFF));
    send_word(mk(FUNC_QUERY, 15, 2, 0, 0, 0));
    send_word(mk(FUNC_ADD, 15, 64, 32'h1234_5678, 0, 0));
    send_word(mk(FUNC_ADD, 7, 0, 32'h10, 0, 0));
    send_word(mk(FUNC_ADD, 7, 7'd100, 32'h20, 0, 0));
    send_word(mk(FUNC_QUERY, 3, 65, 0, 0, 0));
    send_word(mk(FUNC_QUERY, 3, 0, 0, 0, 0));
    send_word(mk(FUNC_QUERY, 3, 1, 0, 0, 0));
    send_word(mk(FUNC_ADD, 15, 1, 32'h5, 0, 0));
    send_word(mk(FUNC_QUERY, 3, 2, 0, 0, 0));
    send_word(mk(FUNC_NOP, 9, 7'h7F, 32'hFFFF_FFFF, 15, 16'hFFFF));
    send_word(mk(FUNC_ADD, 0, 1, 0, 0, 0));
    send_word(mk(FUNC_QUERY, 0, 2, 0, 0, 0));
    set_routing(0);
    send_word(mk(FUNC_QUERY, 3, 2, 0, 0, 0));
    send_word(mk(FUNC_QUERY, 15, 2, 0, 0, 0));
    set_routing(1);
    send_word(mk(FUNC_QUERY, 0, 2, 0, 0, 0));

    random_phase(350);

    // long receiver hold-off while sender keeps offering
    hold_off = 1;
    fork
      begin repeat (400) @(negedge clk); hold_off = 0; end
      random_phase(40);
    join
    drain();

    set_routing(0);
    random_phase(300);
    set_routing(1);
    stall_en = 0;
    random_phase(150);
    stall_en = 1;
    random_phase(200);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_multicore_earliest_start_time_core: PASS");
    else
      $display("tb_multicore_earliest_start_time_core: FAIL");
    $finish;
  end
endmodule
